FILE: rtl/gf2m_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gf2m_pkg
// shared constants and payload types of the GF(2^233) multiplier
// ----------------------------------------------------------------------------
package gf2m_pkg;

	localparam int FIELD_WORDS = 8;
	localparam int WORD_W      = 32;
	localparam int FIELD_DEG   = 233;
	localparam int MID_DEG     = 74;
	localparam int TOP_BITS    = FIELD_DEG - (FIELD_WORDS - 1) * WORD_W;
	localparam int IDX_W       = $clog2(FIELD_WORDS);
	localparam int WINDOW_BITS = 4;

	typedef struct packed {
		logic              operand_sel;
		logic [IDX_W-1:0]  word_index;
		logic [WORD_W-1:0] word_value;
		logic              go;
	} ld_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]  result_index;
		logic [WORD_W-1:0] result_word;
		logic              result_last;
	} res_item_t;

endpackage
`default_nettype wire

FILE: rtl/gf2_233_multiplier.sv
`default_nettype none
// a go transfer starts NWIN = ceil(233 / WINDOW_BITS) window steps (59 at
//   WINDOW_BITS = 4), after which the result words are sent
// loads are stalled from a go transfer until the last result word is taken
// reset: arst_n clears both factor stores and returns the sequencer to idle
// ----------------------------------------------------------------------------
// gf2_233_multiplier
// GF(2^233) multiplier, polynomial basis, modulus x^233 + x^74 + 1, with
// interleaved windowed multiply and fold of the overflow bits each step
// ----------------------------------------------------------------------------
module gf2_233_multiplier
	import gf2m_pkg::*;
#(
	parameter int WINDOW_BITS_P = WINDOW_BITS
) (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       ld_valid,
	output logic      ld_stall,
	input  ld_item_t  ld_item,
	output logic      res_valid,
	input  wire       res_stall,
	output res_item_t res_item
);

	localparam int NWIN   = (FIELD_DEG + WINDOW_BITS_P - 1) / WINDOW_BITS_P;
	localparam int PAD_W  = NWIN * WINDOW_BITS_P;
	localparam int WIN_CW = $clog2(NWIN);
	localparam int EXT_W  = FIELD_DEG + WINDOW_BITS_P;
	localparam int RES_W  = FIELD_WORDS * WORD_W;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_MUL  = 3'b010,
		S_OUT  = 3'b100
	} state_t;

	state_t                   state_q;
	logic [WORD_W-1:0]        factor_a_q [FIELD_WORDS];
	logic [WORD_W-1:0]        factor_b_q [FIELD_WORDS];
	logic [FIELD_DEG-1:0]     acc_q;
	logic [WIN_CW-1:0]        win_q;
	logic [IDX_W-1:0]         ridx_q;

	logic                     ld_xfer;
	logic                     res_xfer;
	logic [FIELD_DEG-1:0]     a_vec;
	logic [FIELD_DEG-1:0]     b_vec;
	logic [PAD_W-1:0]         a_pad;
	logic [WINDOW_BITS_P-1:0] nib;
	logic [EXT_W-1:0]         t_ext;
	logic [WINDOW_BITS_P-1:0] ovf;
	logic [FIELD_DEG-1:0]     red;
	logic [RES_W-1:0]         res_ext;
	logic [IDX_W-1:0]         rev_idx;

	assign ld_stall  = (state_q != S_IDLE);
	assign res_valid = (state_q == S_OUT);
	assign ld_xfer   = ld_valid && !ld_stall;
	assign res_xfer  = res_valid && !res_stall;

	// operand assembly, store word 0 is the top word
	always_comb begin
		a_vec = '0;
		b_vec = '0;
		for (int j = 1; j < FIELD_WORDS; j++) begin
			a_vec[(FIELD_WORDS-1-j)*WORD_W +: WORD_W] = factor_a_q[j];
			b_vec[(FIELD_WORDS-1-j)*WORD_W +: WORD_W] = factor_b_q[j];
		end
		a_vec[FIELD_DEG-1 -: TOP_BITS] = factor_a_q[0][TOP_BITS-1:0];
		b_vec[FIELD_DEG-1 -: TOP_BITS] = factor_b_q[0][TOP_BITS-1:0];
	end

	assign a_pad = PAD_W'(a_vec);
	assign nib   = a_pad[win_q*WINDOW_BITS_P +: WINDOW_BITS_P];

	// one window step: acc * x^w + b * nib, overflow folded back
	always_comb begin
		t_ext = {acc_q, WINDOW_BITS_P'(0)};
		for (int k = 0; k < WINDOW_BITS_P; k++) begin
			if (nib[k]) begin
				t_ext = t_ext ^ (EXT_W'(b_vec) << k);
			end
		end
		ovf = t_ext[EXT_W-1:FIELD_DEG];
		red = t_ext[FIELD_DEG-1:0] ^ FIELD_DEG'(ovf) ^ (FIELD_DEG'(ovf) << MID_DEG);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < FIELD_WORDS; j++) begin
				factor_a_q[j] <= '0;
				factor_b_q[j] <= '0;
			end
		end else if (ld_xfer) begin
			if (ld_item.operand_sel) begin
				factor_b_q[ld_item.word_index] <= ld_item.word_value;
			end else begin
				factor_a_q[ld_item.word_index] <= ld_item.word_value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			win_q   <= '0;
			ridx_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (ld_xfer && ld_item.go) begin
						state_q <= S_MUL;
						win_q   <= WIN_CW'(NWIN - 1);
					end
				end
				S_MUL: begin
					if (win_q == '0) begin
						state_q <= S_OUT;
						ridx_q  <= '0;
					end else begin
						win_q <= win_q - 1'b1;
					end
				end
				S_OUT: begin
					if (res_xfer) begin
						if (ridx_q == IDX_W'(FIELD_WORDS - 1)) begin
							state_q <= S_IDLE;
						end else begin
							ridx_q <= ridx_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			acc_q <= '0;
		end else if (state_q == S_MUL) begin
			acc_q <= red;
		end
	end

	assign res_ext = RES_W'(acc_q);
	assign rev_idx = IDX_W'(FIELD_WORDS - 1) - ridx_q;

	always_comb begin
		res_item.result_index = ridx_q;
		res_item.result_word  = res_ext[rev_idx*WORD_W +: WORD_W];
		res_item.result_last  = (ridx_q == IDX_W'(FIELD_WORDS - 1));
	end

endmodule
`default_nettype wire

FILE: rtl/gf2m_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gf2m_checker
// port-level checks of the multiplier sequencing and result framing
// ----------------------------------------------------------------------------
module gf2m_checker
	import gf2m_pkg::*;
(
	input wire       clk,
	input wire       arst_n,
	input wire       ld_valid,
	input wire       ld_stall,
	input ld_item_t  ld_item,
	input wire       res_valid,
	input wire       res_stall,
	input res_item_t res_item
);

	logic res_xfer;
	assign res_xfer = res_valid && !res_stall;

	// no new load while results are pending
	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ld_stall)
		else $error("load taken while results pending");

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_item.result_last == (res_item.result_index == IDX_W'(FIELD_WORDS - 1))))
		else $error("last flag does not match final index");

	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		(res_xfer && !res_item.result_last) |=>
			(res_valid && res_item.result_index == $past(res_item.result_index) + 1'b1))
		else $error("result index did not advance by one");

	a_end_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(res_xfer && res_item.result_last) |=> (!res_valid && !ld_stall))
		else $error("block not idle after last transfer");

	a_plain_load: assert property (@(posedge clk) disable iff (!arst_n)
		(ld_valid && !ld_stall && !ld_item.go) |=> (!ld_stall && !res_valid))
		else $error("load without go started work");

endmodule

bind gf2_233_multiplier gf2m_checker u_gf2m_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.ld_valid  (ld_valid),
	.ld_stall  (ld_stall),
	.ld_item   (ld_item),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_item  (res_item)
);
`default_nettype wire

FILE: sim/tb_gf2_233_multiplier.sv
// ----------------------------------------------------------------------------
// tb_gf2_233_multiplier
// self-checking bench for the GF(2^233) multiplier: a clocked driver feeds
// operand word loads from a queue, a clocked monitor compares every result
// word against products predicted with a bitwise shift-xor multiply and a
// full fold modulo x^233 + x^74 + 1, under several sender and receiver
// idling mixes and one long receiver hold-off
// ----------------------------------------------------------------------------
module tb_gf2_233_multiplier
	import gf2m_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_PAD   = 100;
	localparam int HOLD_LEN    = 300;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      ld_valid  = 1'b0;
	logic      ld_stall;
	ld_item_t  ld_item   = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	res_item_t res_item;

	ld_item_t  load_feed[$];
	res_item_t pending_words[$];

	logic [WORD_W-1:0] factor_a[FIELD_WORDS];
	logic [WORD_W-1:0] factor_b[FIELD_WORDS];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	bit hold_phase     = 1'b0;
	bit hold_done;
	int hold_cnt;
	int err_count      = 0;
	int cycle_cnt      = 0;

	gf2_233_multiplier u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.ld_valid  (ld_valid),
		.ld_stall  (ld_stall),
		.ld_item   (ld_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

	always #5 clk = ~clk;

	initial begin
		for (int j = 0; j < FIELD_WORDS; j++) begin
			factor_a[j] = '0;
			factor_b[j] = '0;
		end
	end

	function automatic logic [232:0] gf_product(input logic [232:0] x, input logic [232:0] y);
		logic [464:0] acc;
		acc = '0;
		for (int i = 0; i < 233; i++)
			if (x[i])
				acc ^= ({232'b0, y} << i);
		for (int k = 464; k >= 233; k--) begin
			if (acc[k]) begin
				acc[k]       = 1'b0;
				acc[k - 159] = ~acc[k - 159];
				acc[k - 233] = ~acc[k - 233];
			end
		end
		return acc[232:0];
	endfunction

	function automatic logic [232:0] stored_factor(input logic [WORD_W-1:0] w[FIELD_WORDS]);
		logic [255:0] v;
		for (int j = 0; j < FIELD_WORDS; j++)
			v[(FIELD_WORDS - 1 - j) * WORD_W +: WORD_W] = w[j];
		return v[232:0];
	endfunction

	task automatic absorb_load(input ld_item_t it);
		logic [255:0] prod;
		res_item_t    r;
		if (it.operand_sel)
			factor_b[it.word_index] = it.word_value;
		else
			factor_a[it.word_index] = it.word_value;
		if (it.go) begin
			prod = {23'b0, gf_product(stored_factor(factor_a), stored_factor(factor_b))};
			for (int i = 0; i < FIELD_WORDS; i++) begin
				r.result_index = i[IDX_W-1:0];
				r.result_word  = prod[(FIELD_WORDS - 1 - i) * WORD_W +: WORD_W];
				r.result_last  = (i == FIELD_WORDS - 1);
				pending_words.push_back(r);
			end
		end
	endtask

	task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
			input logic [WORD_W-1:0] want);
		$display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_cnt);
		err_count++;
	endtask

	task automatic check_result(input res_item_t got);
		res_item_t want;
		if (pending_words.size() == 0) begin
			report_mismatch("result with nothing pending", got.result_word, '0);
		end else begin
			want = pending_words.pop_front();
			if (got.result_index !== want.result_index)
				report_mismatch("result_index", WORD_W'(got.result_index),
					WORD_W'(want.result_index));
			if (got.result_word !== want.result_word)
				report_mismatch("result_word", got.result_word, want.result_word);
			if (got.result_last !== want.result_last)
				report_mismatch("result_last", WORD_W'(got.result_last),
					WORD_W'(want.result_last));
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_valid <= 1'b0;
			ld_item  <= '0;
		end else begin : drive_body
			bit taken;
			taken = ld_valid && !ld_stall;
			if (taken)
				absorb_load(ld_item);
			if (!ld_valid || taken) begin
				if (load_feed.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					ld_item  <= load_feed.pop_front();
					ld_valid <= 1'b1;
				end else begin
					ld_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			hold_cnt  <= 0;
			hold_done <= 1'b0;
		end else begin
			if (res_valid && !res_stall)
				check_result(res_item);
			if (hold_phase && !hold_done) begin
				res_stall <= 1'b1;
				hold_cnt  <= hold_cnt + 1;
				if (hold_cnt == HOLD_LEN - 1)
					hold_done <= 1'b1;
			end else begin
				res_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic ld_item_t make_load(input logic sel, input logic [IDX_W-1:0] idx,
			input logic [WORD_W-1:0] val, input logic go);
		ld_item_t it;
		it.operand_sel = sel;
		it.word_index  = idx;
		it.word_value  = val;
		it.go          = go;
		return it;
	endfunction

	function automatic logic [WORD_W-1:0] pick_word();
		logic [WORD_W-1:0] one_hot;
		one_hot = 32'h1 << $urandom_range(31);
		case ($urandom_range(7))
			0:       return '0;
			1:       return '1;
			2:       return one_hot;
			3:       return ~one_hot;
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_full_product();
		logic [3:0] order[16];
		logic [3:0] tmp;
		int         r;
		for (int j = 0; j < 16; j++)
			order[j] = j[3:0];
		for (int j = 15; j > 0; j--) begin
			r        = $urandom_range(j);
			tmp      = order[j];
			order[j] = order[r];
			order[r] = tmp;
		end
		for (int j = 0; j < 16; j++)
			load_feed.push_back(make_load(order[j][3], order[j][2:0], pick_word(), j == 15));
	endtask

	task automatic queue_partial_product();
		int n;
		n = $urandom_range(1, 4);
		for (int j = 0; j < n; j++)
			load_feed.push_back(make_load(1'($urandom_range(1)), IDX_W'($urandom_range(7)),
				pick_word(), j == n - 1));
	endtask

	task automatic queue_noise();
		load_feed.push_back(make_load(1'($urandom_range(1)), IDX_W'($urandom_range(7)),
			pick_word(), $urandom_range(3) == 0));
	endtask

	task automatic wait_drained();
		while (load_feed.size() != 0 || ld_valid || pending_words.size() != 0)
			@(negedge clk);
		repeat (DRAIN_PAD) @(negedge clk);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// product of the reset stores
		load_feed.push_back(make_load(1'b0, 3'd7, 32'h0, 1'b1));
		// a = 1 times b = all ones with high garbage in word 0
		load_feed.push_back(make_load(1'b0, 3'd7, 32'h1, 1'b0));
		for (int j = 0; j < FIELD_WORDS; j++)
			load_feed.push_back(make_load(1'b1, j[2:0], 32'hFFFF_FFFF, j == FIELD_WORDS - 1));
		// top bit of a with masked garbage, go without full load
		load_feed.push_back(make_load(1'b0, 3'd0, 32'hFFFF_FF00, 1'b1));
		// both factors all ones
		for (int j = 0; j < FIELD_WORDS; j++)
			load_feed.push_back(make_load(1'b0, j[2:0], 32'hFFFF_FFFF, j == FIELD_WORDS - 1));
		// stores without go, then a store with go
		load_feed.push_back(make_load(1'b1, 3'd4, 32'h0, 1'b0));
		load_feed.push_back(make_load(1'b1, 3'd4, 32'hA5A5_A5A5, 1'b0));
		load_feed.push_back(make_load(1'b0, 3'd3, 32'h8000_0001, 1'b1));
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
				default: begin send_idle_pct = 14; recv_stall_pct = 14; end
			endcase
			queue_full_product();
			queue_partial_product();
			repeat (6) queue_noise();
			wait_drained();
		end

		// long receiver hold-off with the sender pushing
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_phase     = 1'b1;
		queue_full_product();
		repeat (3)
			load_feed.push_back(make_load(1'($urandom_range(1)), IDX_W'($urandom_range(7)),
				pick_word(), 1'b1));
		while (!hold_done)
			@(negedge clk);
		hold_phase = 1'b0;
		wait_drained();

		if (err_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
